### hw/rtl/vdcsl_pkg.sv
// Shared types, constants and per-axis arithmetic for the velocity smoother.
// No dependencies; imported by the top level and by its checker.
package vdcsl_pkg;

  localparam int AXES      = 6;
  localparam int LIN_AXES  = 3;
  localparam int VEL_W     = 16;
  localparam int REG_W     = 15;
  localparam int MASK_W    = AXES;
  localparam int CFG_IDX_W = 3;

  // stream payload layout
  localparam int GOAL_LSB  = MASK_W;
  localparam int IN_BITS   = MASK_W + AXES * VEL_W;
  localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = AXES * VEL_W;

  // register reset values, Q3.12
  localparam logic [REG_W-1:0] MIN_LIN_RST  = 15'd123;
  localparam logic [REG_W-1:0] MIN_ANG_RST  = 15'd614;
  localparam logic [REG_W-1:0] MAX_LIN_RST  = 15'd2048;
  localparam logic [REG_W-1:0] MAX_ANG_RST  = 15'd10240;
  localparam logic [REG_W-1:0] STEP_LIN_RST = 15'd102;
  localparam logic [REG_W-1:0] STEP_ANG_RST = 15'd410;

  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_TICK   = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_LIN  = 3'd0,
    REG_MIN_ANG  = 3'd1,
    REG_MAX_LIN  = 3'd2,
    REG_MAX_ANG  = 3'd3,
    REG_STEP_LIN = 3'd4,
    REG_STEP_ANG = 3'd5
  } cfg_reg_t;

  typedef logic signed [VEL_W-1:0] vel_t;

  // Deadband first, then clamp; magnitude of the most negative value saturates.
  function automatic vel_t verify_goal(vel_t v, logic [REG_W-1:0] lo,
                                       logic [REG_W-1:0] hi);
    logic [VEL_W-1:0] absv;
    logic [REG_W-1:0] mag;
    vel_t             lim;
    absv = v[VEL_W-1] ? VEL_W'(-v) : VEL_W'(v);
    mag  = absv[VEL_W-1] ? {REG_W{1'b1}} : absv[REG_W-1:0];
    lim  = vel_t'({1'b0, hi});
    if (mag < lo) begin
      return '0;
    end else if (mag > hi) begin
      return v[VEL_W-1] ? vel_t'(-lim) : lim;
    end
    return v;
  endfunction

  // Move current toward goal by at most one step, land on goal when close.
  function automatic vel_t smooth(vel_t g, vel_t c, logic [REG_W-1:0] step);
    logic signed [VEL_W:0] ce;
    logic signed [VEL_W:0] ge;
    logic signed [VEL_W:0] st;
    logic signed [VEL_W:0] dn;
    logic signed [VEL_W:0] up;
    ce = {c[VEL_W-1], c};
    ge = {g[VEL_W-1], g};
    st = {2'b00, step};
    dn = ce - st;
    up = ce + st;
    if ((ce - ge) > st) begin
      return dn[VEL_W-1:0];
    end else if ((ge - ce) > st) begin
      return up[VEL_W-1:0];
    end
    return g;
  endfunction

endpackage

### hw/rtl/velocity_deadband_clamp_slew_limiter_unit.sv
// Six-axis velocity smoother: goal deadband and clamp, per-tick slew limit.
// A tick item's result is registered and shows on m_tdata in the cycle after acceptance.
// Throughput: one item per cycle; a result waits in the output register while
// goal updates keep flowing in, and ticks flow whenever that register drains.
// Reset (rst, synchronous): goals and current velocities clear to zero, the
// limit registers return to their default values, and no result is pending.
module velocity_deadband_clamp_slew_limiter_unit
  import vdcsl_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // input item stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // ignore_mask[5:0], goal_lin_x, goal_lin_y, goal_lin_z,
  // goal_ang_x, goal_ang_y, goal_ang_z (16 bits each), zero padding
  input  logic [IN_DATA_W-1:0]    s_tdata,
  // cmd
  input  logic                    s_tuser,
  // result stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // out_lin_x, out_lin_y, out_lin_z, out_ang_x, out_ang_y, out_ang_z
  output logic [OUT_DATA_W-1:0]   m_tdata,
  // register write channel
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [REG_W-1:0]        cfg_data
);

  // limit registers
  logic [REG_W-1:0] min_lin, min_ang, max_lin, max_ang, step_lin, step_ang;

  // per-axis state
  vel_t goal    [AXES];
  vel_t current [AXES];
  vel_t goal_next    [AXES];
  vel_t current_next [AXES];

  logic [OUT_DATA_W-1:0] out_data;
  logic                  out_valid;

  logic                  out_free;
  logic                  in_fire;
  logic                  tick_fire;
  logic                  upd_fire;
  logic [MASK_W-1:0]     ignore_mask;

  // Writes are always taken; software must write only while the block is idle (not enforced here).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_lin  <= MIN_LIN_RST;
      min_ang  <= MIN_ANG_RST;
      max_lin  <= MAX_LIN_RST;
      max_ang  <= MAX_ANG_RST;
      step_lin <= STEP_LIN_RST;
      step_ang <= STEP_ANG_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_LIN:  min_lin  <= cfg_data;
        REG_MIN_ANG:  min_ang  <= cfg_data;
        REG_MAX_LIN:  max_lin  <= cfg_data;
        REG_MAX_ANG:  max_ang  <= cfg_data;
        REG_STEP_LIN: step_lin <= cfg_data;
        REG_STEP_ANG: step_ang <= cfg_data;
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // A tick needs room in the output register; a goal update never does.
  assign out_free  = !out_valid || m_tready;
  assign s_tready  = out_free || (s_tuser == CMD_UPDATE);
  assign in_fire   = s_tvalid && s_tready;
  assign tick_fire = in_fire && (s_tuser == CMD_TICK);
  assign upd_fire  = in_fire && (s_tuser == CMD_UPDATE);
  assign ignore_mask = s_tdata[MASK_W-1:0];

  // Six independent lanes: verify the new goal, or slew current toward goal.
  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      goal_next[i]    = goal[i];
      current_next[i] = current[i];
      if (upd_fire && !ignore_mask[i]) begin
        if (i < LIN_AXES) begin
          goal_next[i] = verify_goal(s_tdata[GOAL_LSB + i*VEL_W +: VEL_W],
                                     min_lin, max_lin);
        end else begin
          goal_next[i] = verify_goal(s_tdata[GOAL_LSB + i*VEL_W +: VEL_W],
                                     min_ang, max_ang);
        end
      end
      if (tick_fire) begin
        current_next[i] = smooth(goal[i], current[i],
                                 (i < LIN_AXES) ? step_lin : step_ang);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        goal[i]    <= '0;
        current[i] <= '0;
      end
    end else begin
      for (int i = 0; i < AXES; i++) begin
        goal[i]    <= goal_next[i];
        current[i] <= current_next[i];
      end
    end
  end

  // Output register: load on a tick, hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tick_fire) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_fire) begin
      for (int i = 0; i < AXES; i++) begin
        out_data[i*VEL_W +: VEL_W] <= current_next[i];
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

### hw/rtl/vdcsl_checker.sv
// Port-level checks for the velocity smoother, bound to its top level.
// Depends on vdcsl_pkg and on velocity_deadband_clamp_slew_limiter_unit.
module vdcsl_checker
  import vdcsl_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  s_tuser,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // no result pending straight after reset
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // an empty output register never blocks input
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with output empty");

  // every accepted tick yields a result next cycle
  a_tick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_TICK) |=> m_tvalid)
    else $error("tick gave no result");

  // a goal update into a draining output produces nothing
  a_upd: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == CMD_UPDATE) && (!m_tvalid || m_tready)
    |=> !m_tvalid)
    else $error("goal update produced a result");

endmodule

bind velocity_deadband_clamp_slew_limiter_unit vdcsl_checker u_vdcsl_checker (.*);
